FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the RTL. The enclosing module
// must have a clock named clk and an active-high reset named rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/rrmtp_pkg.sv
// ---------------------------------------------------------------------------
// rrmtp_pkg
// Types, codes and helpers shared by the postfix regex prefix evaluator.
// ---------------------------------------------------------------------------
package rrmtp_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int MAX_LENGTH_DEF  = 65536;
  localparam int QUEUE_DEPTH     = 4;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_TARGET      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_FIRST = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_LAST  = 2'd2;

  localparam logic [7:0] TARGET_RESET      = 8'd97;
  localparam logic [7:0] ALPHA_FIRST_RESET = 8'd97;
  localparam logic [7:0] ALPHA_LAST_RESET  = 8'd99;

  localparam logic [7:0] SYM_ONE  = 8'h31;
  localparam logic [7:0] SYM_PLUS = 8'h2B;
  localparam logic [7:0] SYM_CAT  = 8'h2E;
  localparam logic [7:0] SYM_STAR = 8'h2A;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_BAD_TARGET = 3'd2;
  localparam logic [2:0] ST_FEW_ARGS   = 3'd3;
  localparam logic [2:0] ST_UNKNOWN    = 3'd4;
  localparam logic [2:0] ST_EXTRA      = 3'd5;
  localparam logic [2:0] ST_OVERFLOW   = 3'd6;

  localparam logic [2:0] OP_PUSH     = 3'd0;
  localparam logic [2:0] OP_PLUS     = 3'd1;
  localparam logic [2:0] OP_CAT      = 3'd2;
  localparam logic [2:0] OP_STAR     = 3'd3;
  localparam logic [2:0] OP_UNKNOWN  = 3'd4;
  localparam logic [2:0] OP_OVERFLOW = 3'd5;
  localparam logic [2:0] OP_EMPTY    = 3'd6;

  localparam logic [30:0] LEN_INF   = 31'h7FFF_FFFF;
  localparam logic [31:0] WORD_INF  = 32'h7FFF_FFFF;
  localparam logic [31:0] WORD_NONE = 32'hFFFF_FFFF;
  localparam logic [31:0] WORD_ZERO = 32'h0000_0000;
  localparam logic [31:0] WORD_ONE  = 32'h0000_0001;

  // The word length is two's complement; all ones means no whole word.
  typedef struct packed {
    logic [30:0] prefix;
    logic [31:0] word;
  } pair_t;

  typedef struct packed {
    logic [2:0]  op;
    logic        last;
    logic        bad_target;
    logic        hit;
    logic        word_zero;
    logic [15:0] pos;
  } cmd_t;

  // When both operands are non-negative and below 2^31, the sum fits 32 bits.
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] s;
    s = a + b;
    return (s > WORD_INF) ? WORD_INF : s;
  endfunction

  function automatic logic [31:0] word_max(input logic [31:0] a, input logic [31:0] b);
    return ($signed(a) > $signed(b)) ? a : b;
  endfunction

endpackage

FILE: hw/rtl/regex_rpn_max_target_prefix.sv
// ---------------------------------------------------------------------------
// regex_rpn_max_target_prefix: postfix regex target-prefix evaluator.
// A result is registered after its last symbol has passed the command queue.
// Throughput: one symbol per cycle while symbol_stall is low.
// Sync reset: clears queue, counters, error latch, result_valid; loads config.
// ---------------------------------------------------------------------------
module regex_rpn_max_target_prefix #(
  parameter int STACK_DEPTH = rrmtp_pkg::STACK_DEPTH_DEF,
  parameter int MAX_LENGTH  = rrmtp_pkg::MAX_LENGTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rrmtp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rrmtp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              symbol_valid,
  output logic                              symbol_stall,
  input  logic [7:0]                        symbol,
  input  logic                              last,
  input  logic                              empty_expr,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [30:0]                       longest_prefix,
  output logic [2:0]                        status,
  output logic [15:0]                       error_position
);
  import rrmtp_pkg::*;

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic take;
  logic queue_full;
  logic queue_nonempty;
  logic queue_pop;

  assign symbol_stall = queue_full;
  assign take         = symbol_valid && !queue_full;

  rrmtp_front #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .symbol    (symbol),
    .last      (last),
    .empty_expr(empty_expr),
    .take      (take),
    .cmd       (front_cmd)
  );

  rrmtp_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (take),
    .wdata   (front_cmd),
    .full    (queue_full),
    .pop     (queue_pop),
    .rdata   (queue_cmd),
    .nonempty(queue_nonempty)
  );

  rrmtp_back #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd           (queue_cmd),
    .cmd_valid     (queue_nonempty),
    .cmd_pop       (queue_pop),
    .result_stall  (result_stall),
    .result_valid  (result_valid),
    .longest_prefix(longest_prefix),
    .status        (status),
    .error_position(error_position)
  );

endmodule

FILE: hw/rtl/rrmtp_front.sv
// ---------------------------------------------------------------------------
// rrmtp_front
// Holds the configuration, counts symbol positions and turns each accepted
// symbol into a stack command for the back end.
// ---------------------------------------------------------------------------
module rrmtp_front #(
  parameter int MAX_LENGTH = rrmtp_pkg::MAX_LENGTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [rrmtp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rrmtp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [7:0]                         symbol,
  input  logic                               last,
  input  logic                               empty_expr,
  input  logic                               take,
  output rrmtp_pkg::cmd_t                    cmd
);
  import rrmtp_pkg::*;

  localparam int PW = $clog2(MAX_LENGTH + 1);

  logic [7:0]    target;
  logic [7:0]    alpha_first;
  logic [7:0]    alpha_last;
  logic [PW-1:0] position;
  logic [PW-1:0] position_next;
  logic          sym_in_alpha;
  logic          pos_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      target      <= TARGET_RESET;
      alpha_first <= ALPHA_FIRST_RESET;
      alpha_last  <= ALPHA_LAST_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TARGET:      target      <= cfg_data;
        REG_ALPHA_FIRST: alpha_first <= cfg_data;
        REG_ALPHA_LAST:  alpha_last  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pos_full     = (position >= PW'(MAX_LENGTH));
  assign sym_in_alpha = (symbol >= alpha_first) && (symbol <= alpha_last);

  always_comb begin
    cmd            = '0;
    cmd.last       = last;
    cmd.bad_target = !((target >= alpha_first) && (target <= alpha_last));
    cmd.hit        = (symbol == target);
    cmd.word_zero  = (symbol == SYM_ONE);
    cmd.pos        = 16'(position);
    if (empty_expr) begin
      cmd.op = OP_EMPTY;
    end else if (pos_full) begin
      cmd.op = OP_OVERFLOW;
    end else if (sym_in_alpha || symbol == SYM_ONE) begin
      cmd.op = OP_PUSH;
    end else begin
      case (symbol)
        SYM_PLUS: cmd.op = OP_PLUS;
        SYM_CAT:  cmd.op = OP_CAT;
        SYM_STAR: cmd.op = OP_STAR;
        default:  cmd.op = OP_UNKNOWN;
      endcase
    end
  end

  always_comb begin
    position_next = position;
    if (empty_expr || last) begin
      position_next = '0;
    end else if (!pos_full) begin
      position_next = position + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (take) begin
      position <= position_next;
    end
  end

endmodule

FILE: hw/rtl/rrmtp_fifo.sv
// ---------------------------------------------------------------------------
// rrmtp_fifo
// Short command queue between the front end and the stack back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rrmtp_fifo #(
  parameter int DEPTH = rrmtp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rrmtp_pkg::cmd_t wdata,
  output logic            full,
  input  logic            pop,
  output rrmtp_pkg::cmd_t rdata,
  output logic            nonempty
);
  import rrmtp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_fifo_overrun, push && full, "command written into a full queue")
  `ASSERT_PROP(a_fifo_grow, (push && !pop) |=> (count == $past(count) + 1'b1), "queue fill count lost a transfer")

endmodule

FILE: hw/rtl/rrmtp_ram.sv
// ---------------------------------------------------------------------------
// rrmtp_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module rrmtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/rrmtp_back.sv
// ---------------------------------------------------------------------------
// rrmtp_back
// Executes stack commands on a pair stack whose top two entries live in
// registers, spills the rest to a RAM, latches errors and holds the result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rrmtp_back #(
  parameter int STACK_DEPTH = rrmtp_pkg::STACK_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  rrmtp_pkg::cmd_t cmd,
  input  logic            cmd_valid,
  output logic            cmd_pop,
  input  logic            result_stall,
  output logic            result_valid,
  output logic [30:0]     longest_prefix,
  output logic [2:0]      status,
  output logic [15:0]     error_position
);
  import rrmtp_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PAIR_W = $bits(pair_t);

  logic [CW-1:0] count;
  logic [2:0]    error_code;
  logic [15:0]   error_index;
  pair_t         top;
  pair_t         second;
  logic          byp_valid;
  pair_t         byp_data;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [PAIR_W-1:0] ram_rdata;
  pair_t         third;

  logic          emit;
  logic          take;
  logic          spill;
  pair_t         push_pair;
  pair_t         plus_pair;
  pair_t         cat_pair;
  logic [31:0]   cat_sum_p;
  logic [31:0]   cat_sum_w;

  logic [CW-1:0] count_step;
  logic [2:0]    err_step;
  logic [15:0]   eidx_step;
  pair_t         top_step;
  pair_t         second_step;
  logic [CW-1:0] count_next;

  logic [30:0]   res_prefix;
  logic [2:0]    res_status;
  logic [15:0]   res_pos;

  assign emit    = (cmd.op == OP_EMPTY) || cmd.last;
  assign take    = cmd_valid && (!emit || !result_valid || !result_stall);
  assign cmd_pop = take;
  assign third   = byp_valid ? byp_data : pair_t'(ram_rdata);

  always_comb begin
    push_pair.prefix = {30'b0, cmd.hit};
    if (cmd.word_zero) begin
      push_pair.word = WORD_ZERO;
    end else if (cmd.hit) begin
      push_pair.word = WORD_ONE;
    end else begin
      push_pair.word = WORD_NONE;
    end

    plus_pair.prefix = (second.prefix > top.prefix) ? second.prefix : top.prefix;
    plus_pair.word   = word_max(second.word, top.word);

    cat_sum_p = sat_add(second.word, {1'b0, top.prefix});
    cat_sum_w = sat_add(second.word, top.word);
    if (!second.word[31] && (cat_sum_p > {1'b0, second.prefix})) begin
      cat_pair.prefix = cat_sum_p[30:0];
    end else begin
      cat_pair.prefix = second.prefix;
    end
    if (top.word[31] || second.word[31]) begin
      cat_pair.word = WORD_NONE;
    end else begin
      cat_pair.word = cat_sum_w;
    end
  end

  always_comb begin
    count_step  = count;
    err_step    = error_code;
    eidx_step   = error_index;
    top_step    = top;
    second_step = second;
    spill       = 1'b0;
    if (error_code == ST_OK) begin
      case (cmd.op)
        OP_PUSH: begin
          if (count >= CW'(STACK_DEPTH)) begin
            err_step  = ST_OVERFLOW;
            eidx_step = cmd.pos;
          end else begin
            spill       = (count >= CW'(2));
            second_step = top;
            top_step    = push_pair;
            count_step  = count + 1'b1;
          end
        end
        OP_PLUS, OP_CAT: begin
          if (count < CW'(2)) begin
            err_step  = ST_FEW_ARGS;
            eidx_step = cmd.pos;
          end else begin
            top_step    = (cmd.op == OP_PLUS) ? plus_pair : cat_pair;
            second_step = third;
            count_step  = count - 1'b1;
          end
        end
        OP_STAR: begin
          if (count == '0) begin
            err_step  = ST_FEW_ARGS;
            eidx_step = cmd.pos;
          end else if (!top.word[31] && (top.word != WORD_ZERO)) begin
            top_step.prefix = LEN_INF;
            top_step.word   = WORD_INF;
          end else begin
            top_step.word = WORD_ZERO;
          end
        end
        OP_UNKNOWN: begin
          err_step  = ST_UNKNOWN;
          eidx_step = cmd.pos;
        end
        OP_OVERFLOW: begin
          err_step  = ST_OVERFLOW;
          eidx_step = cmd.pos;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_prefix = '0;
    res_status = ST_OK;
    res_pos    = '0;
    if (cmd.op == OP_EMPTY) begin
      res_status = ST_EMPTY;
    end else if (cmd.bad_target) begin
      res_status = ST_BAD_TARGET;
    end else if (err_step != ST_OK) begin
      res_status = err_step;
      res_pos    = eidx_step;
    end else if (count_step > CW'(1)) begin
      res_status = ST_EXTRA;
      res_pos    = cmd.pos;
    end else if (count_step == '0) begin
      res_status = ST_FEW_ARGS;
      res_pos    = cmd.pos;
    end else begin
      res_prefix = top_step.prefix;
    end
  end

  always_comb begin
    if (!take) begin
      count_next = count;
    end else if (emit) begin
      count_next = '0;
    end else begin
      count_next = count_step;
    end
  end

  // With the bypass register, the RAM always presents the entry just below the two cached ones.
  assign ram_we    = take && !emit && spill;
  assign ram_waddr = AW'(count - CW'(2));
  assign ram_raddr = (count_next >= CW'(3)) ? AW'(count_next - CW'(3)) : '0;

  rrmtp_ram #(
    .WIDTH(PAIR_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(second),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    byp_data <= second;
    if (take && !emit) begin
      top    <= top_step;
      second <= second_step;
    end
    if (take && emit) begin
      longest_prefix <= res_prefix;
      status         <= res_status;
      error_position <= res_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      error_code   <= ST_OK;
      error_index  <= '0;
      byp_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      count     <= count_next;
      byp_valid <= ram_we && (ram_waddr == ram_raddr);
      if (take) begin
        if (emit) begin
          error_code  <= ST_OK;
          error_index <= '0;
        end else begin
          error_code  <= err_step;
          error_index <= eidx_step;
        end
      end
      if (take && emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  `ASSERT_PROP(a_clear_after_result, (take && emit) |=> (count == '0 && error_code == ST_OK && result_valid), "expression state not cleared after a result")
  `ASSERT_PROP(a_error_freezes_stack, (error_code != ST_OK && !(take && emit)) |=> (error_code == $past(error_code) && count == $past(count)), "stack changed after a latched error")
  `ASSERT_NEVER(a_count_bound, count > CW'(STACK_DEPTH), "stack count above stack depth")

endmodule
